/* src/pli_pkg.sv */
// pli_pkg: shared types and constants of the piecewise linear interpolator
// no dependencies; used by the interfaces, controller, datapath and top level

package pli_pkg;

  localparam int DEFAULT_MAX_KEYS = 64;
  localparam int WORD_W           = 32;
  localparam int ENTRY_W          = 6;
  localparam int COUNT_W          = 7;
  localparam int FRAC_W           = 16;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = COUNT_W;
  localparam int PROD_W           = WORD_W + 1 + FRAC_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_COUNT = 1'b1;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_VRD0,
    ST_VRD1,
    ST_DIFF,
    ST_MUL,
    ST_SUM
  } pli_state_t;

  typedef struct packed {
    logic wr_en;
    logic start;
    logic scan_step;
    logic div_step;
    logic rd_right;
    logic cap_v0;
    logic cap_diff;
    logic cap_prod;
    logic load_out;
  } pli_cmd_t;

  typedef struct packed {
    logic counts_ok;
    logic key_le;
    logic found;
    logic scan_last;
    logic div_last;
    logic out_free;
  } pli_status_t;

endpackage

/* src/pli_in_if.sv */
// pli_in_if: input channel carrying write and query words
// depends on pli_pkg for field widths

interface pli_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic        [pli_pkg::ENTRY_W-1:0]  entry_index;
  logic signed [pli_pkg::WORD_W-1:0]   key_word;
  logic signed [pli_pkg::WORD_W-1:0]   value_word;
  logic signed [pli_pkg::WORD_W-1:0]   fraction;

  modport source (
    output valid, action, entry_index, key_word, value_word, fraction,
    input  ready
  );

  modport sink (
    input  valid, action, entry_index, key_word, value_word, fraction,
    output ready
  );
endinterface

/* src/pli_out_if.sv */
// pli_out_if: result channel carrying interpolated words
// depends on pli_pkg for the word width

interface pli_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pli_pkg::WORD_W-1:0] interpolated;

  modport source (
    output valid, interpolated,
    input  ready
  );

  modport sink (
    input  valid, interpolated,
    output ready
  );
endinterface

/* src/pli_ctrl.sv */
// pli_ctrl: sequencing state machine of the interpolator
// depends on pli_pkg for the state type and the command and status structs

module pli_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_action,
  input  pli_pkg::pli_status_t status,
  output logic                 item_ready,
  output pli_pkg::pli_cmd_t    cmd
);

  pli_pkg::pli_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pli_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      pli_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          if (item_action == pli_pkg::ACT_WRITE) begin
            cmd.wr_en = 1'b1;
          end else if (status.counts_ok) begin
            cmd.start  = 1'b1;
            state_next = pli_pkg::ST_SCAN;
          end
        end
      end
      pli_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        priority if (status.key_le && !status.scan_last) begin
          state_next = pli_pkg::ST_SCAN;
        end else if (!status.key_le && status.found) begin
          state_next = pli_pkg::ST_DIV;
        end else begin
          state_next = pli_pkg::ST_VRD0;
        end
      end
      pli_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = pli_pkg::ST_VRD0;
        end
      end
      pli_pkg::ST_VRD0: begin
        state_next = pli_pkg::ST_VRD1;
      end
      pli_pkg::ST_VRD1: begin
        cmd.rd_right = 1'b1;
        cmd.cap_v0   = 1'b1;
        state_next   = pli_pkg::ST_DIFF;
      end
      pli_pkg::ST_DIFF: begin
        cmd.cap_diff = 1'b1;
        state_next   = pli_pkg::ST_MUL;
      end
      pli_pkg::ST_MUL: begin
        cmd.cap_prod = 1'b1;
        state_next   = pli_pkg::ST_SUM;
      end
      pli_pkg::ST_SUM: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = pli_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pli_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* src/pli_datapath.sv */
// pli_datapath: key and value tables, scan, serial divider, multiply and output word
// depends on pli_pkg; driven by pli_ctrl through the command struct

module pli_datapath #(
  parameter int MAX_KEYS = pli_pkg::DEFAULT_MAX_KEYS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic        [pli_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [pli_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic        [pli_pkg::ENTRY_W-1:0]   entry_index,
  input  logic signed [pli_pkg::WORD_W-1:0]    key_word,
  input  logic signed [pli_pkg::WORD_W-1:0]    value_word,
  input  logic signed [pli_pkg::WORD_W-1:0]    fraction,
  input  pli_pkg::pli_cmd_t                    cmd,
  output pli_pkg::pli_status_t                 status,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [pli_pkg::WORD_W-1:0]    interpolated
);

  localparam int IDX_W  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CNT_W  = $clog2(MAX_KEYS + 1);
  localparam int DCNT_W = $clog2(pli_pkg::FRAC_W);
  localparam int W      = pli_pkg::WORD_W;
  localparam int SUM_W  = W + 3;
  localparam int SHR_W  = pli_pkg::PROD_W - pli_pkg::FRAC_W;

  logic [W-1:0] key_mem   [MAX_KEYS];
  logic [W-1:0] value_mem [MAX_KEYS];

  logic [pli_pkg::COUNT_W-1:0] key_count, value_count;
  logic [W-1:0]                key_q, value_q;
  logic [IDX_W-1:0]            key_raddr, value_raddr, waddr;
  logic                        wr_ok;

  logic signed [W-1:0]       f, kl, v0;
  logic [IDX_W-1:0]          scan_i, left, right;
  logic                      found;
  logic [W-1:0]              rem, den;
  logic [pli_pkg::FRAC_W-1:0] t_quot;
  logic [DCNT_W-1:0]         div_cnt;
  logic signed [W:0]         diff;
  logic signed [pli_pkg::PROD_W-1:0] prod;

  logic [CNT_W-1:0]          scan_len;
  logic [W:0]                rem2;
  logic                      rem_ge;
  logic signed [SHR_W-1:0]   prod_shr;
  logic signed [SUM_W-1:0]   sum;
  logic signed [W-1:0]       sat;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count   <= '0;
      value_count <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pli_pkg::REG_KEY_COUNT:   key_count   <= cfg_data;
        pli_pkg::REG_VALUE_COUNT: value_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // tables
  assign waddr       = IDX_W'(entry_index);
  assign wr_ok       = cmd.wr_en && (32'(entry_index) < MAX_KEYS);
  assign key_raddr   = cmd.scan_step ? IDX_W'(scan_i + 1'b1) : '0;
  assign value_raddr = cmd.rd_right ? right : left;

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      key_mem[waddr]   <= key_word;
      value_mem[waddr] <= value_word;
    end
    key_q   <= key_mem[key_raddr];
    value_q <= value_mem[value_raddr];
  end

  // status
  assign scan_len = (32'(key_count) > MAX_KEYS) ? CNT_W'(MAX_KEYS) : CNT_W'(key_count);
  assign status.counts_ok = (key_count == value_count) && (key_count != '0);
  assign status.key_le    = $signed(key_q) <= f;
  assign status.found     = found;
  assign status.scan_last = (CNT_W'(scan_i) == scan_len - CNT_W'(1));
  assign status.div_last  = (div_cnt == DCNT_W'(pli_pkg::FRAC_W - 1));
  assign status.out_free  = !out_valid || out_ready;

  // restoring divider step
  assign rem2   = {rem, 1'b0};
  assign rem_ge = rem2 >= {1'b0, den};

  // scan, divide, multiply
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      f       <= fraction;
      scan_i  <= '0;
      left    <= '0;
      right   <= '0;
      found   <= 1'b0;
      t_quot  <= '0;
      div_cnt <= '0;
    end
    if (cmd.scan_step) begin
      if (status.key_le) begin
        kl     <= $signed(key_q);
        left   <= scan_i;
        right  <= scan_i;
        found  <= 1'b1;
        scan_i <= scan_i + 1'b1;
      end else if (found) begin
        right <= scan_i;
        den   <= key_q - kl;
        rem   <= f - kl;
      end
    end
    if (cmd.div_step) begin
      rem     <= rem_ge ? W'(rem2 - {1'b0, den}) : rem2[W-1:0];
      t_quot  <= {t_quot[pli_pkg::FRAC_W-2:0], rem_ge};
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.cap_v0) begin
      v0 <= $signed(value_q);
    end
    if (cmd.cap_diff) begin
      diff <= $signed({value_q[W-1], value_q}) - $signed({v0[W-1], v0});
    end
    if (cmd.cap_prod) begin
      prod <= diff * $signed({1'b0, t_quot});
    end
  end

  // floor scaling, sum and saturation
  assign prod_shr = prod[pli_pkg::PROD_W-1:pli_pkg::FRAC_W];
  assign sum      = SUM_W'(v0) + SUM_W'(prod_shr);

  always_comb begin
    priority if (sum > SUM_W'(signed'({1'b0, {(W-1){1'b1}}}))) begin
      sat = {1'b0, {(W-1){1'b1}}};
    end else if (sum < -SUM_W'(signed'({1'b0, {(W-1){1'b1}}})) - SUM_W'(1)) begin
      sat = {1'b1, {(W-1){1'b0}}};
    end else begin
      sat = sum[W-1:0];
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      interpolated <= sat;
    end
  end

endmodule

/* src/piecewise_linear_interpolator_top.sv */
// piecewise_linear_interpolator_top: piecewise linear scalar interpolator
// depends on pli_pkg, pli_in_if, pli_out_if, pli_ctrl and pli_datapath
//
// usage
//   item channel: a write word (action 0) stores key_word and value_word at
//   entry_index and gives no result; a query word (action 1) brings a
//   Q16.16 fraction and gives one interpolated word when key_count equals
//   value_count and is not zero, otherwise none
//   result channel: one saturated Q16.16 word per valid query
//   config port: cfg_write with cfg_index 0 (key_count) or 1 (value_count)
// query sequence
//   a query is accepted in the idle state, then scans the keys up to the
//   first key above the fraction (at most MAX_KEYS), runs the serial
//   divider when the fraction lies between two keys, and then reads the
//   two values, subtracts, multiplies and sums; the key scan and the
//   one-bit-a-cycle divider set the length of a query
// reset and stall
//   reset clears the counts and the result flag; the tables are undefined
//   until written. a waiting result is held in the output register; new
//   words are taken meanwhile, and a query stalls at its last step

module piecewise_linear_interpolator_top #(
  parameter int MAX_KEYS = pli_pkg::DEFAULT_MAX_KEYS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  pli_in_if.sink                                item,
  pli_out_if.source                             result,
  input  logic                                  cfg_write,
  input  logic        [pli_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [pli_pkg::CFG_DATA_W-1:0] cfg_data
);

  pli_pkg::pli_cmd_t    cmd;
  pli_pkg::pli_status_t status;

  pli_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item.valid),
    .item_action (item.action),
    .status      (status),
    .item_ready  (item.ready),
    .cmd         (cmd)
  );

  pli_datapath #(
    .MAX_KEYS (MAX_KEYS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .entry_index  (item.entry_index),
    .key_word     (item.key_word),
    .value_word   (item.value_word),
    .fraction     (item.fraction),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (result.ready),
    .out_valid    (result.valid),
    .interpolated (result.interpolated)
  );

  // a result word is never overwritten while it waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!result.valid || result.ready))
    else $error("result word overwritten");

  // table writes only on an accepted write word
  a_write_accepted: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> (item.valid && item.ready && item.action == pli_pkg::ACT_WRITE))
    else $error("table write without accepted write word");

  // phases of a query never overlap
  a_phases: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.start, cmd.scan_step, cmd.div_step, cmd.cap_v0, cmd.cap_diff,
              cmd.cap_prod, cmd.load_out}))
    else $error("overlapping query phases");

  // a query start is followed by the key scan
  a_start_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (cmd.scan_step && !item.ready))
    else $error("query start not followed by scan");

endmodule

/* tb/sv/piecewise_linear_interpolator_top_test.sv */
`timescale 1ns / 100ps
// piecewise_linear_interpolator_top_test: self-checking bench for the interpolator top level
// depends on pli_pkg, pli_in_if, pli_out_if and piecewise_linear_interpolator_top
// a directed table, then random key tables and queries checked against an interpolation predictor

module piecewise_linear_interpolator_top_test;
  import pli_pkg::*;

  localparam int MAX_KEYS      = DEFAULT_MAX_KEYS;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int TOTAL_WORDS   = 950;
  localparam int QUIET_WORDS   = 150;

  typedef struct packed {
    logic               action;
    logic [ENTRY_W-1:0] entry_index;
    logic [WORD_W-1:0]  key_word;
    logic [WORD_W-1:0]  value_word;
    logic [WORD_W-1:0]  fraction;
  } word_t;

  typedef enum logic {ROW_WORD, ROW_COUNT} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    word_t                w;
    logic [CFG_IDX_W-1:0] reg_sel;
    logic [COUNT_W-1:0]   count;
    logic                 fixed;
    logic [WORD_W-1:0]    want;
  } test_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pli_in_if  item_ch ();
  pli_out_if result_ch ();

  piecewise_linear_interpolator_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  logic signed [WORD_W-1:0] key_tab [MAX_KEYS];
  logic signed [WORD_W-1:0] val_tab [MAX_KEYS];
  logic [COUNT_W-1:0]       key_cnt;
  logic [COUNT_W-1:0]       val_cnt;
  logic [WORD_W-1:0]        pending_interp [$];

  test_row_t stimulus_rows [$];
  int        error_count = 0;
  int        words_sent = 0;
  bit        gaps_on;
  bit        hold_asked;
  logic [WORD_W-1:0] oldest;

  always #2 clk = ~clk;

  function automatic bit interpolate(input logic [WORD_W-1:0] frac,
                                     output logic [WORD_W-1:0] res);
    int     n, lft, rgt, i;
    bit     hit;
    longint fl, kl, kr, t, v0, v1, r;
    res = '0;
    if (key_cnt != val_cnt || key_cnt == 0) return 1'b0;
    n = key_cnt > MAX_KEYS ? MAX_KEYS : int'(key_cnt);
    fl = $signed(frac);
    lft = 0;
    hit = 1'b0;
    i = 0;
    while (i < n && key_tab[i] <= fl) begin
      lft = i;
      hit = 1'b1;
      i++;
    end
    rgt = hit ? lft + 1 : 0;
    if (rgt > n - 1) rgt = n - 1;
    t = 0;
    if (lft != rgt) begin
      kl = key_tab[lft];
      kr = key_tab[rgt];
      if (kr != kl) t = ((fl - kl) <<< 16) / (kr - kl);
      if (t > 64'sh0000_FFFF) t = 64'sh0000_FFFF;
    end
    v0 = val_tab[lft];
    v1 = val_tab[rgt];
    r = v0 + (((v1 - v0) * t) >>> 16);
    if (r > 64'sh7FFF_FFFF) r = 64'sh7FFF_FFFF;
    if (r < -64'sh8000_0000) r = -64'sh8000_0000;
    res = r[31:0];
    return 1'b1;
  endfunction

  // query position: half the time between neighbouring keys, else on a key, at the edges or noise
  function automatic logic [WORD_W-1:0] pick_fraction(input int m);
    int                i;
    longint            lo, hi;
    longint unsigned   span;
    i = $urandom_range(0, m - 1);
    lo = key_tab[i];
    hi = (i + 1 < m) ? longint'(key_tab[i + 1]) : lo;
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return key_tab[i];
      2: return key_tab[0] - 32'd1;
      3: return key_tab[m - 1] + 32'($urandom_range(0, 255));
      default: begin
        if (hi <= lo) return key_tab[i];
        span = hi - lo;
        return 32'(lo + longint'({$urandom, $urandom} % span));
      end
    endcase
  endfunction

  function automatic void add_word(input logic act, input logic [ENTRY_W-1:0] idx,
                                   input logic [WORD_W-1:0] kw, input logic [WORD_W-1:0] vw,
                                   input logic [WORD_W-1:0] fr, input logic fixed,
                                   input logic [WORD_W-1:0] want);
    test_row_t row;
    row = '0;
    row.kind = ROW_WORD;
    row.w = {act, idx, kw, vw, fr};
    row.fixed = fixed;
    row.want = want;
    stimulus_rows.push_back(row);
  endfunction

  function automatic void add_count(input logic [CFG_IDX_W-1:0] sel,
                                    input logic [COUNT_W-1:0] value);
    test_row_t row;
    row = '0;
    row.kind = ROW_COUNT;
    row.reg_sel = sel;
    row.count = value;
    stimulus_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  task automatic offer_word(input word_t w, input logic fixed, input logic [WORD_W-1:0] want);
    logic [WORD_W-1:0] res;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      item_ch.valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    item_ch.valid       = 1'b1;
    item_ch.action      = w.action;
    item_ch.entry_index = w.entry_index;
    item_ch.key_word    = w.key_word;
    item_ch.value_word  = w.value_word;
    item_ch.fraction    = w.fraction;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    words_sent++;
    if (w.action == ACT_WRITE) begin
      key_tab[w.entry_index] = w.key_word;
      val_tab[w.entry_index] = w.value_word;
    end else if (interpolate(w.fraction, res)) begin
      pending_interp.push_back(fixed ? want : res);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (pending_interp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [CFG_IDX_W-1:0] sel, input logic [COUNT_W-1:0] value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = sel;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
    if (sel == REG_KEY_COUNT) key_cnt = value;
    else val_cnt = value;
  endtask

  task automatic run_phase(input int kc, input int vc, input int queries, input bit squeeze);
    int     m, mode;
    bit     wide_vals;
    longint acc, stepmax;
    word_t  w;
    settle();
    write_count(REG_KEY_COUNT, 7'(kc));
    write_count(REG_VALUE_COUNT, 7'(vc));
    m = kc > MAX_KEYS ? MAX_KEYS : kc;
    mode = $urandom_range(0, 3);
    wide_vals = $urandom_range(0, 1);
    if (mode == 1) begin
      acc = -64'sd2147483648;
      stepmax = 64'sh1_0000_0000 / (m + 1);
    end else begin
      acc = longint'($urandom_range(0, 'h80000)) - 64'sh40000;
      stepmax = 64'sh30000;
    end
    // ascending keys with the odd repeat, or an unsorted table
    for (int k = 0; k < m; k++) begin
      w.action      = ACT_WRITE;
      w.entry_index = ENTRY_W'(k);
      if (mode == 2) w.key_word = $urandom;
      else w.key_word = acc > 64'sh7FFF_FFFF ? 32'h7FFF_FFFF : 32'(acc);
      w.value_word  = wide_vals ? $urandom : 32'($urandom_range(0, 'h200000)) - 32'h100000;
      w.fraction    = $urandom;
      offer_word(w, 1'b0, '0);
      if ($urandom_range(0, 7) != 0) acc += longint'($urandom) % stepmax + 1;
    end
    if (squeeze) hold_asked = 1'b1;
    repeat (queries) begin
      if ($urandom_range(0, 9) == 0) begin
        w.action      = ACT_WRITE;
        w.entry_index = ENTRY_W'($urandom_range(0, MAX_KEYS - 1));
        w.key_word    = $urandom;
        w.value_word  = $urandom;
        w.fraction    = $urandom;
        offer_word(w, 1'b0, '0);
      end
      w.action      = ACT_QUERY;
      w.entry_index = ENTRY_W'($urandom);
      w.key_word    = $urandom;
      w.value_word  = $urandom;
      w.fraction    = m == 0 ? $urandom : pick_fraction(m);
      offer_word(w, 1'b0, '0);
    end
  endtask

  // result side
  initial begin
    int pause, hold_left;
    bit hold_taken;
    pause = 0;
    hold_left = 0;
    hold_taken = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asked && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready = 1'b0;
      end else if (pause > 0) begin
        pause--;
        result_ch.ready = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        pause = $urandom_range(0, 6);
        result_ch.ready = 1'b0;
      end else begin
        result_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_interp.size() == 0) begin
        report_mismatch("word with no query waiting", result_ch.interpolated, '0);
      end else begin
        oldest = pending_interp.pop_front();
        if (result_ch.interpolated !== oldest)
          report_mismatch("interpolated", result_ch.interpolated, oldest);
      end
    end
  end

  initial begin
    int pick, kc, vc;
    rst                 = 1'b1;
    cfg_write           = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    item_ch.valid       = 1'b0;
    item_ch.action      = ACT_WRITE;
    item_ch.entry_index = '0;
    item_ch.key_word    = '0;
    item_ch.value_word  = '0;
    item_ch.fraction    = '0;
    gaps_on             = 1'b1;
    hold_asked          = 1'b0;
    key_cnt             = '0;
    val_cnt             = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // counts zero after reset
    add_word(ACT_QUERY, 6'd0, 32'h0, 32'h0, 32'h0001_0000, 1'b0, '0);
    add_word(ACT_WRITE, 6'd0, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);
    add_word(ACT_WRITE, 6'd1, 32'h0000_0000, 32'h8000_0000, 32'h0, 1'b0, '0);
    add_word(ACT_WRITE, 6'd2, 32'h0001_0000, 32'h0010_0000, 32'h0, 1'b0, '0);
    add_word(ACT_WRITE, 6'd3, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0, '0);
    add_word(ACT_WRITE, 6'd63, 32'h8000_0000, 32'h0000_1234, 32'h8000_0000, 1'b0, '0);
    // count mismatch
    add_count(REG_KEY_COUNT, 7'd4);
    add_count(REG_VALUE_COUNT, 7'd3);
    add_word(ACT_QUERY, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_8000, 1'b0, '0);
    add_count(REG_VALUE_COUNT, 7'd4);
    // below first key, exactly on keys (the last one too), between keys
    add_word(ACT_QUERY, 6'd0, 32'h0, 32'h0, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF);
    add_word(ACT_QUERY, 6'd0, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    add_word(ACT_QUERY, 6'd0, 32'h0, 32'h0, 32'hFFFF_0000, 1'b1, 32'h7FFF_FFFF);
    add_word(ACT_QUERY, 6'd0, 32'h0, 32'h0, 32'h0001_0000, 1'b1, 32'h0010_0000);
    add_word(ACT_QUERY, 6'd0, 32'h0, 32'h0, 32'h0000_8000, 1'b0, '0);
    add_word(ACT_QUERY, 6'd0, 32'h0, 32'h0, 32'hFFFF_8000, 1'b0, '0);
    add_word(ACT_QUERY, 6'd0, 32'h0, 32'h0, 32'h4000_0000, 1'b0, '0);
    // single key
    add_count(REG_KEY_COUNT, 7'd1);
    add_count(REG_VALUE_COUNT, 7'd1);
    add_word(ACT_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 1'b1, 32'h7FFF_FFFF);
    // counts above the table size compared as written
    add_count(REG_KEY_COUNT, 7'd100);
    add_count(REG_VALUE_COUNT, 7'd64);
    add_word(ACT_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 1'b0, '0);

    foreach (stimulus_rows[r]) begin
      if (stimulus_rows[r].kind == ROW_COUNT) begin
        settle();
        write_count(stimulus_rows[r].reg_sel, stimulus_rows[r].count);
      end else begin
        offer_word(stimulus_rows[r].w, stimulus_rows[r].fixed, stimulus_rows[r].want);
      end
    end

    run_phase(64, 64, 12, 1'b0);
    run_phase(127, 127, 12, 1'b0);
    run_phase(0, 0, 4, 1'b0);
    run_phase(3, 3, 30, 1'b1);
    while (words_sent < TOTAL_WORDS) begin
      if (words_sent > TOTAL_WORDS - QUIET_WORDS) gaps_on = 1'b0;
      pick = $urandom_range(0, 19);
      if (pick < 13) kc = $urandom_range(1, 8);
      else if (pick < 17) kc = $urandom_range(9, 64);
      else if (pick < 18) kc = $urandom_range(65, 127);
      else kc = $urandom_range(0, 2);
      vc = pick == 19 ? $urandom_range(0, 127) : kc;
      run_phase(kc, vc, $urandom_range(8, 30), 1'b0);
    end
    settle();

    if (error_count == 0 && pending_interp.size() == 0) begin
      $display("piecewise_linear_interpolator_top regression: pass");
    end else begin
      $display("piecewise_linear_interpolator_top regression: fail");
    end
    $finish;
  end

  initial begin
    #2_500_000;
    $display("piecewise_linear_interpolator_top regression: fail");
    $finish;
  end

endmodule

/* piecewise_linear_interpolator_top.f */
src/pli_pkg.sv
src/pli_in_if.sv
src/pli_out_if.sv
src/pli_ctrl.sv
src/pli_datapath.sv
src/piecewise_linear_interpolator_top.sv
tb/sv/piecewise_linear_interpolator_top_test.sv
